// File: rtl/core/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants and register index codes of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

   localparam int MAX_PATTERN_BYTES_DEF = 32;
   localparam int OFFSET_BITS_DEF       = 32;

   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int MATCH_OFFSET_W = 32;
   localparam int PATTERN_WORDS = 4;
   localparam int CARE_MASK_W  = 32;
   localparam int PATTERN_LENGTH_W = 6;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_WORD_0 = 3'd0,
      CSR_PATTERN_WORD_1 = 3'd1,
      CSR_PATTERN_WORD_2 = 3'd2,
      CSR_PATTERN_WORD_3 = 3'd3,
      CSR_CARE_MASK      = 3'd4,
      CSR_PATTERN_LENGTH = 3'd5
   } csr_index_type;

endpackage

`default_nettype wire

// File: rtl/core/mbps_csr.sv
// ----------------------------------------------------------------------------
// mbps_csr
// Configuration registers, length clamp and a registered copy of the pattern
// and care mask aligned to window positions (position 0 is the newest byte).
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_csr #(
   parameter int MAX_PATTERN_BYTES = 32,
   parameter int LEN_W             = 6,
   parameter int PIDX_W            = 5
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mbps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [mbps_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic [MAX_PATTERN_BYTES*8-1:0]          aligned_pattern,
   output logic [MAX_PATTERN_BYTES-1:0]            aligned_care,
   output logic [LEN_W-1:0]                        used_length
);
   import mbps_pkg::*;

   logic [CSR_DATA_W-1:0]       pattern_word_ff [PATTERN_WORDS];
   logic [CARE_MASK_W-1:0]      care_mask_ff;
   logic [PATTERN_LENGTH_W-1:0] pattern_length_ff;

   logic [7:0]                   pattern_bytes [MAX_PATTERN_BYTES];
   logic [LEN_W-1:0]             length_in;
   logic [MAX_PATTERN_BYTES*8-1:0] pattern_in;
   logic [MAX_PATTERN_BYTES-1:0] care_in;

   logic [MAX_PATTERN_BYTES*8-1:0] pattern_ff;
   logic [MAX_PATTERN_BYTES-1:0] care_ff;
   logic [LEN_W-1:0]             length_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < PATTERN_WORDS; w++) begin
            pattern_word_ff[w] <= '0;
         end
         care_mask_ff      <= '0;
         pattern_length_ff <= PATTERN_LENGTH_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_WORD_0: pattern_word_ff[0] <= csr_data;
            CSR_PATTERN_WORD_1: pattern_word_ff[1] <= csr_data;
            CSR_PATTERN_WORD_2: pattern_word_ff[2] <= csr_data;
            CSR_PATTERN_WORD_3: pattern_word_ff[3] <= csr_data;
            CSR_CARE_MASK:      care_mask_ff      <= csr_data[CARE_MASK_W-1:0];
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[PATTERN_LENGTH_W-1:0];
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_bytes
      assign pattern_bytes[i] = pattern_word_ff[i / 8][(i % 8) * 8 +: 8];
   end

   always_comb begin
      if (pattern_length_ff == '0) begin
         length_in = LEN_W'(1);
      end else if (pattern_length_ff > PATTERN_LENGTH_W'(MAX_PATTERN_BYTES)) begin
         length_in = LEN_W'(MAX_PATTERN_BYTES);
      end else begin
         length_in = pattern_length_ff[LEN_W-1:0];
      end
   end

   // window position j holds pattern byte length-1-j
   always_comb begin
      logic [LEN_W-1:0] pidx;
      pattern_in = '0;
      care_in    = '0;
      pidx       = '0;
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         pidx = length_in - LEN_W'(1) - LEN_W'(j);
         if (LEN_W'(j) < length_in) begin
            pattern_in[j*8 +: 8] = pattern_bytes[pidx[PIDX_W-1:0]];
            care_in[j]           = care_mask_ff[pidx[PIDX_W-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         care_ff    <= '0;
         length_ff  <= LEN_W'(1);
      end else begin
         pattern_ff <= pattern_in;
         care_ff    <= care_in;
         length_ff  <= length_in;
      end
   end

   assign aligned_pattern = pattern_ff;
   assign aligned_care    = care_ff;
   assign used_length     = length_ff;

endmodule

`default_nettype wire

// File: rtl/core/mbps_scan.sv
// ----------------------------------------------------------------------------
// mbps_scan
// Shift window, region byte counter and the parallel masked compare.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_scan #(
   parameter int MAX_PATTERN_BYTES = 32,
   parameter int OFFSET_BITS       = 32,
   parameter int LEN_W             = 6
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 step,
   input  wire logic [7:0]                           data_byte,
   input  wire logic                                 end_of_region,
   input  wire logic [MAX_PATTERN_BYTES*8-1:0]       aligned_pattern,
   input  wire logic [MAX_PATTERN_BYTES-1:0]         aligned_care,
   input  wire logic [LEN_W-1:0]                     used_length,
   output logic                                      hit,
   output logic                                      found,
   output logic [mbps_pkg::MATCH_OFFSET_W-1:0]       match_offset
);
   import mbps_pkg::*;

   logic [7:0]             window_ff [MAX_PATTERN_BYTES];
   logic [7:0]             window_in [MAX_PATTERN_BYTES];
   logic [OFFSET_BITS-1:0] count_ff;
   logic [OFFSET_BITS-1:0] count_in;
   logic                   reported_ff;

   logic                   bytes_equal;
   logic                   match;
   logic [OFFSET_BITS-1:0] diff;
   logic [63:0]            diff_wide;

   always_comb begin
      window_in[0] = data_byte;
      for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   assign count_in = (&count_ff) ? count_ff : count_ff + OFFSET_BITS'(1);

   always_comb begin
      bytes_equal = 1'b1;
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         if (aligned_care[j] && (window_in[j] != aligned_pattern[j*8 +: 8])) begin
            bytes_equal = 1'b0;
         end
      end
   end

   assign match     = bytes_equal && (count_in >= OFFSET_BITS'(used_length));
   assign diff      = count_in - OFFSET_BITS'(used_length);
   assign diff_wide = 64'(diff);

   assign hit          = !reported_ff && (match || end_of_region);
   assign found        = match;
   assign match_offset = match ? diff_wide[MATCH_OFFSET_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (step && !reported_ff) begin
         for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            window_ff[k] <= window_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         reported_ff <= 1'b0;
      end else if (step) begin
         if (end_of_region) begin
            count_ff    <= '0;
            reported_ff <= 1'b0;
         end else if (!reported_ff) begin
            count_ff <= count_in;
            if (match) begin
               reported_ff <= 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/masked_byte_pattern_scanner.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Scans a byte stream for a wildcard byte signature and reports the start
// offset of the first match in each region, or not found at region end.
//
//   channel | ports                                   | dir
//   --------+-----------------------------------------+-----
//   req     | req_valid/ready, data_byte, end_of_reg. | in
//   rsp     | rsp_valid/ready, found, match_offset    | out
//   csr     | csr_valid/ready, csr_index, csr_data    | in
//
// One byte per cycle while results are taken and no register beat is offered;
// a beat waits in the input register, and its result is registered as it leaves.
// The window compare reads the registered copy of the aligned pattern and care.
// Synchronous reset clears control state and loads register defaults.
// A held result stalls the input stage only when a new byte reaches compare;
// a register beat holds off the byte channel while it is offered.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_byte_pattern_scanner #(
   parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF,
   parameter int OFFSET_BITS       = mbps_pkg::OFFSET_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [7:0]                         req_data_byte,
   input  wire logic                               req_end_of_region,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_found,
   output logic [mbps_pkg::MATCH_OFFSET_W-1:0]     rsp_match_offset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mbps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [mbps_pkg::CSR_DATA_W-1:0]    csr_data
);
   import mbps_pkg::*;

   localparam int LEN_W  = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int PIDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

   logic [MAX_PATTERN_BYTES*8-1:0] aligned_pattern;
   logic [MAX_PATTERN_BYTES-1:0]   aligned_care;
   logic [LEN_W-1:0]               used_length;

   logic                        in_valid_ff;
   logic                        in_valid_in;
   logic [7:0]                  in_byte_ff;
   logic                        in_end_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        rsp_found_ff;
   logic [MATCH_OFFSET_W-1:0]   rsp_offset_ff;

   logic                        req_fire;
   logic                        proc_fire;
   logic                        hit;
   logic                        found;
   logic [MATCH_OFFSET_W-1:0]   match_offset;

   mbps_csr #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
      .LEN_W             (LEN_W),
      .PIDX_W            (PIDX_W)
   ) u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .aligned_pattern (aligned_pattern),
      .aligned_care    (aligned_care),
      .used_length     (used_length)
   );

   mbps_scan #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
      .OFFSET_BITS       (OFFSET_BITS),
      .LEN_W             (LEN_W)
   ) u_scan (
      .clock           (clock),
      .reset           (reset),
      .step            (proc_fire),
      .data_byte       (in_byte_ff),
      .end_of_region   (in_end_ff),
      .aligned_pattern (aligned_pattern),
      .aligned_care    (aligned_care),
      .used_length     (used_length),
      .hit             (hit),
      .found           (found),
      .match_offset    (match_offset)
   );

   assign proc_fire = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (!in_valid_ff || proc_fire) && !csr_valid;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      if (proc_fire) begin
         rsp_valid_in = hit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_data_byte;
         in_end_ff  <= req_end_of_region;
      end
      if (proc_fire && hit) begin
         rsp_found_ff  <= found;
         rsp_offset_ff <= match_offset;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff;

endmodule

`default_nettype wire

// File: verif/signature_scan_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signature_scan_checker
// Watches the byte, result and register channels of the scanner. It keeps its
// own copy of the registers, the byte window and the region counter, predicts
// the report that each accepted byte causes, and compares every result beat
// field by field, in order, with the oldest predicted report.
// ----------------------------------------------------------------------------
module signature_scan_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  req_end_of_region,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic                                  rsp_found,
   input  logic [mbps_pkg::MATCH_OFFSET_W-1:0]   rsp_match_offset,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [mbps_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]       csr_data,
   output int unsigned                           error_count,
   output int unsigned                           pending_count,
   output int unsigned                           found_count,
   output int unsigned                           miss_count
);
   import mbps_pkg::*;

   localparam int WINDOW_BYTES = MAX_PATTERN_BYTES_DEF;

   typedef struct packed {
      logic                      found;
      logic [MATCH_OFFSET_W-1:0] offset;
   } scan_report_type;

   scan_report_type             expected_reports [$];
   logic [CSR_DATA_W-1:0]       sig_word [PATTERN_WORDS];
   logic [CARE_MASK_W-1:0]      care_bits;
   logic [PATTERN_LENGTH_W-1:0] sig_length;
   logic [7:0]                  recent_bytes [WINDOW_BYTES];
   logic [OFFSET_BITS_DEF-1:0]  seen_count;
   logic                        region_matched;
   int unsigned                 fault_total = 0;
   int unsigned                 found_tally = 0;
   int unsigned                 miss_tally  = 0;

   task automatic clear_region();
      foreach (recent_bytes[k]) recent_bytes[k] = '0;
      seen_count     = '0;
      region_matched = 1'b0;
   endtask

   task automatic note_fault(input string what);
      fault_total++;
      if (fault_total <= 10) $display("[%0t] mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin : track
      int unsigned     len;
      logic            hit;
      scan_report_type report;
      scan_report_type oldest;
      if (reset) begin
         expected_reports.delete();
         foreach (sig_word[k]) sig_word[k] = '0;
         care_bits  = '0;
         sig_length = PATTERN_LENGTH_W'(1);
         clear_region();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_PATTERN_WORD_0: sig_word[0] = csr_data;
               CSR_PATTERN_WORD_1: sig_word[1] = csr_data;
               CSR_PATTERN_WORD_2: sig_word[2] = csr_data;
               CSR_PATTERN_WORD_3: sig_word[3] = csr_data;
               CSR_CARE_MASK:      care_bits  = csr_data[CARE_MASK_W-1:0];
               CSR_PATTERN_LENGTH: sig_length = csr_data[PATTERN_LENGTH_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            len = (sig_length == '0) ? 1 :
                  (sig_length > WINDOW_BYTES) ? WINDOW_BYTES : sig_length;
            if (!region_matched) begin
               for (int k = WINDOW_BYTES - 1; k > 0; k--)
                  recent_bytes[k] = recent_bytes[k-1];
               recent_bytes[0] = req_data_byte;
               if (seen_count != '1) seen_count = seen_count + 1'b1;
               // oldest byte of the window lines up with pattern byte 0
               hit = (seen_count >= len);
               for (int i = 0; i < len; i++) begin
                  if (care_bits[i] &&
                      recent_bytes[len-1-i] != sig_word[i/8][(i%8)*8 +: 8])
                     hit = 1'b0;
               end
               if (hit) begin
                  report.found   = 1'b1;
                  report.offset  = MATCH_OFFSET_W'(seen_count - len);
                  region_matched = 1'b1;
                  expected_reports.insert(expected_reports.size(), report);
               end else if (req_end_of_region) begin
                  report = '0;
                  expected_reports.insert(expected_reports.size(), report);
               end
            end
            if (req_end_of_region) clear_region();
         end

         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               note_fault($sformatf("unexpected result beat found=%0b offset=%0d",
                                    rsp_found, rsp_match_offset));
            end else begin
               oldest = expected_reports.pop_front();
               if (rsp_found !== oldest.found)
                  note_fault($sformatf("found: expected %0b, got %0b",
                                       oldest.found, rsp_found));
               if (rsp_match_offset !== oldest.offset)
                  note_fault($sformatf("match_offset: expected %0d, got %0d",
                                       oldest.offset, rsp_match_offset));
               if (oldest.found) found_tally++;
               else              miss_tally++;
            end
         end
      end
      error_count   <= fault_total;
      pending_count <= expected_reports.size();
      found_count   <= found_tally;
      miss_count    <= miss_tally;
   end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the masked byte pattern scanner with directed regions for reset
// defaults, length clamping, wildcards, short regions, matches on the last
// byte and mid-region register changes, then with random regions that mostly
// carry the configured signature among near-miss bytes. Both channels idle at
// random; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
   import mbps_pkg::*;

   localparam int          TARGET_BYTES  = 1200;
   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int          SETTLE_CYCLES = 8;

   logic                      clock;
   logic                      reset             = 1'b1;
   logic                      req_valid         = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_data_byte     = '0;
   logic                      req_end_of_region = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready         = 1'b0;
   logic                      rsp_found;
   logic [MATCH_OFFSET_W-1:0] rsp_match_offset;
   logic                      csr_valid         = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index         = '0;
   logic [CSR_DATA_W-1:0]     csr_data          = '0;

   int unsigned error_count, pending_count, found_count, miss_count;
   int unsigned cycle_count;
   int unsigned bytes_sent    = 0;
   int unsigned regions_sent  = 0;
   int unsigned config_writes = 0;
   logic        req_quiet     = 1'b0;

   logic [CSR_DATA_W-1:0]       cfg_word [PATTERN_WORDS];
   logic [CARE_MASK_W-1:0]      cfg_mask;
   logic [PATTERN_LENGTH_W-1:0] cfg_len;

   masked_byte_pattern_scanner DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_region (req_end_of_region),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_match_offset  (rsp_match_offset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   signature_scan_checker scan_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_region (req_end_of_region),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_match_offset  (rsp_match_offset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .error_count       (error_count),
      .pending_count     (pending_count),
      .found_count       (found_count),
      .miss_count        (miss_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned draw_wait(input logic quiet);
      return quiet ? 0 : $urandom_range(0, 15);
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic region_end);
      int unsigned pause;
      if ($urandom_range(0, 63) == 0) req_quiet = !req_quiet;
      pause = draw_wait(req_quiet);
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_data_byte     <= value;
      req_end_of_region <= region_end;
      req_valid         <= 1'b1;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
      if (region_end) regions_sent++;
   endtask

   // no beat in flight and no report outstanding
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config();
      logic [CSR_DATA_W-1:0] value;
      for (int r = CSR_PATTERN_WORD_0; r <= CSR_PATTERN_LENGTH; r++) begin
         case (csr_index_type'(r))
            CSR_CARE_MASK:      value = {32'($urandom), cfg_mask};
            CSR_PATTERN_LENGTH: value = {32'($urandom), 26'($urandom), cfg_len};
            default:            value = cfg_word[r];
         endcase
         csr_index <= CSR_INDEX_W'(r);
         csr_data  <= value;
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
         config_writes++;
      end
      csr_valid <= 1'b0;
   endtask

   task automatic load_config(input logic [CSR_DATA_W-1:0] word0,
                              input logic [CARE_MASK_W-1:0] mask,
                              input logic [PATTERN_LENGTH_W-1:0] len);
      settle();
      cfg_word[0] = word0;
      cfg_mask    = mask;
      cfg_len     = len;
      write_config();
   endtask

   task automatic reconfigure();
      int unsigned pick;
      settle();
      foreach (cfg_word[k]) cfg_word[k] = {32'($urandom), 32'($urandom)};
      pick = $urandom_range(0, 19);
      if (pick < 11)      cfg_len = PATTERN_LENGTH_W'($urandom_range(1, 6));
      else if (pick < 15) cfg_len = PATTERN_LENGTH_W'($urandom_range(7, 32));
      else if (pick < 17) cfg_len = (pick == 15) ? 6'd1 : 6'd32;
      else if (pick < 18) cfg_len = 6'd0;
      else                cfg_len = PATTERN_LENGTH_W'($urandom_range(33, 63));
      pick = $urandom_range(0, 9);
      if (pick < 4)       cfg_mask = '1;
      else if (pick == 4) cfg_mask = '0;
      else                cfg_mask = $urandom;
      write_config();
   endtask

   task automatic random_region();
      logic [7:0]  body [$];
      logic [7:0]  sig_bytes [MAX_PATTERN_BYTES_DEF];
      int unsigned plen, span, at, cut;
      plen = (cfg_len == '0) ? 1 :
             (cfg_len > MAX_PATTERN_BYTES_DEF) ? MAX_PATTERN_BYTES_DEF : cfg_len;
      for (int i = 0; i < MAX_PATTERN_BYTES_DEF; i++)
         sig_bytes[i] = cfg_word[i/8][(i%8)*8 +: 8];
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64)
                                         : $urandom_range(1, plen + 12);
      // half of the filler comes from the signature itself for near misses
      for (int i = 0; i < span; i++)
         body.insert(body.size(),
                     $urandom_range(0, 1) ? sig_bytes[$urandom_range(0, plen - 1)]
                                          : 8'($urandom));
      if (span >= plen && $urandom_range(0, 9) < 7) begin
         at = $urandom_range(0, span - plen);
         for (int i = 0; i < plen; i++)
            if (cfg_mask[i]) body[at + i] = sig_bytes[i];
         if ($urandom_range(0, 7) == 0)
            body[at + $urandom_range(0, plen - 1)] ^= 8'($urandom_range(1, 255));
      end
      cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, span) : span;
      for (int i = 0; i < span; i++) begin
         if (i == cut) reconfigure();
         send_byte(body[i], i == span - 1);
      end
   endtask

   initial begin : rsp_side
      int unsigned pause;
      logic        rsp_quiet;
      rsp_quiet = 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 47) == 0) rsp_quiet = !rsp_quiet;
         pause = draw_wait(rsp_quiet);
         if (pause > 0) begin
            rsp_ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d reports outstanding",
               CYCLE_LIMIT, pending_count);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      foreach (cfg_word[k]) cfg_word[k] = '0;
      cfg_mask = '0;
      cfg_len  = 6'd1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: length 1, all wildcard, so the first byte matches
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);

      cfg_word[1] = '0;
      cfg_word[2] = '1;
      cfg_word[3] = 64'h5AA5_0FF0_C33C_9669;
      // care bits past the length set; match ends on the last byte
      load_config(64'hFFFF_FFFF_EFBE_ADDE, '1, 6'd4);
      send_byte(8'h11, 1'b0);
      send_byte(8'hDE, 1'b0);
      send_byte(8'hAD, 1'b0);
      send_byte(8'hBE, 1'b0);
      send_byte(8'hEF, 1'b1);
      send_byte(8'hDE, 1'b0);
      send_byte(8'hAD, 1'b1);
      send_byte(8'hDE, 1'b0);
      send_byte(8'hAD, 1'b0);
      send_byte(8'hBE, 1'b0);
      send_byte(8'h00, 1'b1);

      // length 0 clamps to 1
      load_config(64'hFFFF_FFFF_EFBE_ADDE, 32'h0000_0001, 6'd0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hDE, 1'b1);

      // length 63 clamps to 32; region too short
      load_config(64'hFFFF_FFFF_EFBE_ADDE, '0, 6'd63);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b1);

      // registers change mid-region, window and count carry over
      load_config(64'h0000_0000_0000_CDAB, 32'h0000_0003, 6'd2);
      send_byte(8'h12, 1'b0);
      send_byte(8'hAB, 1'b0);
      load_config(64'h0000_0000_0077_0012, 32'h0000_0005, 6'd3);
      send_byte(8'h77, 1'b1);

      reconfigure();
      while (bytes_sent < TARGET_BYTES) begin
         if ($urandom_range(0, 3) == 0) reconfigure();
         random_region();
      end

      settle();
      $display("covered %0d bytes in %0d regions with %0d register beats",
               bytes_sent, regions_sent, config_writes);
      $display("checked %0d matches and %0d regions without a match",
               found_count, miss_count);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/mbps_pkg.sv
rtl/core/mbps_csr.sv
rtl/core/mbps_scan.sv
rtl/core/masked_byte_pattern_scanner.sv
verif/signature_scan_checker.sv
verif/tb_top.sv
